// File: src/piece_table_text_editor_unit_defines.svh
// ----------------------------------------------------------------------------
// piece_table_text_editor_unit_defines
// Assertion macros used by the piece-table editor RTL.
// ----------------------------------------------------------------------------
`ifndef PIECE_TABLE_TEXT_EDITOR_UNIT_DEFINES_SVH
`define PIECE_TABLE_TEXT_EDITOR_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define PTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define PTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Types, codes and sizing constants of the piece-table editor.
// ----------------------------------------------------------------------------
`default_nettype none

package pte_pkg;

    localparam int ORIGINAL_DEPTH_DEF = 4096;
    localparam int ADDED_DEPTH_DEF    = 4096;
    localparam int MAX_PIECES_DEF     = 64;

    localparam int OFF_W = 17;   // holds any store offset up to 65536
    localparam int LEN_W = 14;
    localparam logic [LEN_W-1:0] LENGTH_LIMIT = 14'd16383;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [13:0] position;
        logic [13:0] count;
        logic [7:0]  data_byte;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [13:0] total_length;
    } res_t;

    typedef struct packed {
        logic             src;   // 0 original, 1 added
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } piece_t;

    typedef enum logic [1:0] {
        OP_READ,
        OP_INSERT,
        OP_DEL
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LOCATED,
        S_RD_DATA,
        S_INS_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_W0,
        S_INS_W1,
        S_INS_W2,
        S_DEL_DECIDE,
        S_DEL_WH,
        S_DEL_WT
    } state_t;

endpackage

`default_nettype wire

// File: src/pte_byte_ram.sv
// ----------------------------------------------------------------------------
// pte_byte_ram
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pte_byte_ram #(
    parameter int DEPTH = pte_pkg::ORIGINAL_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/pte_piece_ram.sv
// ----------------------------------------------------------------------------
// pte_piece_ram
// Piece list store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pte_piece_ram #(
    parameter int MAX_PIECES = pte_pkg::MAX_PIECES_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(MAX_PIECES)-1:0] waddr,
    input  pte_pkg::piece_t               wdata,
    input  logic [$clog2(MAX_PIECES)-1:0] raddr,
    output pte_pkg::piece_t               rdata
);

    pte_pkg::piece_t mem [MAX_PIECES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/piece_table_text_editor_unit.sv
// ----------------------------------------------------------------------------
// piece_table_text_editor_unit
// Piece-table text store with load, insert, delete and single-byte read.
// ----------------------------------------------------------------------------
// Usage
//   Command channel: a word on cmd is taken at a rising edge with start high
//   and busy low. Load and insert runs send one word per byte; the run's
//   first word carries kind, position and count, later words only data_byte.
//   Result channel: done is high for exactly one cycle with the result word;
//   the receiver cannot stall, so results are never held back.
// Operation steps
//   Bytes inside a run are taken while busy stays low and give no result. A
//   load or an insert of zero bytes, an operation rejected on its range or
//   on store space and the end of a load run answer in the cycle after
//   acceptance. The piece walk sets the rest: each visited piece takes an
//   address step, then a check of the registered piece memory data. A read
//   walks to its piece, then fetches the byte. An insert end that extends a
//   piece or appends ends after the walk; a splice moves the pieces above
//   the insert point up, each read then written, then writes the new piece
//   and, when a piece is split, both halves. A delete walks twice (both
//   range ends) and moves the tail pieces, each read then written.
// Reset
//   rst_n clears piece count, text length, add-store fill and the run state.
//   Stores are left as they are; pieces only cover written bytes.
// Memories are accessed by one state at a time, so no forwarding is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module piece_table_text_editor_unit #(
    parameter int ORIGINAL_DEPTH = pte_pkg::ORIGINAL_DEPTH_DEF,
    parameter int ADDED_DEPTH    = pte_pkg::ADDED_DEPTH_DEF,
    parameter int MAX_PIECES     = pte_pkg::MAX_PIECES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pte_pkg::cmd_t cmd,
    output logic          done,
    output pte_pkg::res_t result
);

`include "piece_table_text_editor_unit_defines.svh"

    localparam int OA_W  = $clog2(ORIGINAL_DEPTH);
    localparam int AA_W  = $clog2(ADDED_DEPTH);
    localparam int AL_W  = $clog2(ADDED_DEPTH + 1);
    localparam int IDX_W = $clog2(MAX_PIECES);
    localparam int PC_W  = $clog2(MAX_PIECES + 1);
    localparam int MW    = PC_W + 1;
    localparam logic [17:0] OD_L = 18'(ORIGINAL_DEPTH);
    localparam logic [17:0] AD_L = 18'(ADDED_DEPTH);
    localparam logic [MW-1:0] MAXP = MW'(MAX_PIECES);

    // ---------------------------------------------------------------- state
    pte_pkg::state_t state_reg, state_next;

    logic [PC_W-1:0]  count_reg, count_next;
    logic [13:0]      tl_reg, tl_next;
    logic [AL_W-1:0]  added_reg, added_next;

    logic             run_open_reg, run_open_next;
    logic [1:0]       run_kind_reg, run_kind_next;
    logic [13:0]      run_pos_reg, run_pos_next;
    logic [13:0]      run_total_reg, run_total_next;
    logic [13:0]      run_recv_reg, run_recv_next;
    logic [1:0]       run_rej_reg, run_rej_next;

    pte_pkg::op_t     op_reg, op_next;
    logic             phase_reg, phase_next;
    logic [13:0]      target_reg, target_next;
    logic [13:0]      del_n_reg, del_n_next;

    // walk
    logic [PC_W-1:0]  scan_i_reg, scan_i_next;
    logic [13:0]      acc_reg, acc_next;
    logic             found_reg, found_next;
    logic [PC_W-1:0]  loc_idx_reg, loc_idx_next;
    logic [13:0]      within_reg, within_next;
    pte_pkg::piece_t  hit_reg, hit_next;
    pte_pkg::piece_t  prev_reg, prev_next;

    // delete bookkeeping
    logic [PC_W-1:0]  i0_reg, i0_next;
    logic [13:0]      w0_reg, w0_next;
    pte_pkg::piece_t  head_reg, head_next;
    logic             dh_reg, dh_next;
    logic             dt_reg, dt_next;
    logic [PC_W-1:0]  dm_reg, dm_next;

    // shift engine
    logic [PC_W-1:0]  sh_src_reg, sh_src_next;
    logic [PC_W-1:0]  sh_dst_reg, sh_dst_next;
    logic [PC_W-1:0]  sh_left_reg, sh_left_next;
    logic             sh_desc_reg, sh_desc_next;
    logic             split_reg, split_next;

    logic             fetch_ok_reg, fetch_ok_next;
    logic             fetch_src_reg, fetch_src_next;

    logic             done_reg, done_next;
    pte_pkg::res_t    res_reg, res_next;

    // ---------------------------------------------------------------- memories
    logic              pw_we;
    logic [IDX_W-1:0]  pw_addr, pr_addr;
    pte_pkg::piece_t   pw_data, pr_data;
    logic              ow_we, aw_we;
    logic [OA_W-1:0]   ow_addr, or_addr;
    logic [AA_W-1:0]   aw_addr, ar_addr;
    logic [7:0]        o_q, a_q;

    pte_piece_ram #(.MAX_PIECES(MAX_PIECES)) u_pieces (
        .clk   (clk),
        .we    (pw_we),
        .waddr (pw_addr),
        .wdata (pw_data),
        .raddr (pr_addr),
        .rdata (pr_data)
    );

    pte_byte_ram #(.DEPTH(ORIGINAL_DEPTH)) u_original (
        .clk   (clk),
        .we    (ow_we),
        .waddr (ow_addr),
        .wdata (cmd.data_byte),
        .raddr (or_addr),
        .rdata (o_q)
    );

    pte_byte_ram #(.DEPTH(ADDED_DEPTH)) u_added (
        .clk   (clk),
        .we    (aw_we),
        .waddr (aw_addr),
        .wdata (cmd.data_byte),
        .raddr (ar_addr),
        .rdata (a_q)
    );

    // ---------------------------------------------------------------- idle decode
    logic             accept;
    logic             dec_emit, dec_clear, dec_open, dec_step, dec_last;
    logic             dec_load_done, dec_scan;
    logic [1:0]       dec_status;
    pte_pkg::op_t     dec_op;
    logic [13:0]      dec_target, dec_del_n, avail;
    logic [1:0]       eff_kind, eff_rej;
    logic [13:0]      eff_pos, eff_total, eff_recv;

    assign accept = start && (state_reg == pte_pkg::S_IDLE);
    assign avail  = tl_reg - cmd.position;

    always_comb
    begin
        dec_emit      = 1'b0;
        dec_clear     = 1'b0;
        dec_open      = 1'b0;
        dec_step      = 1'b0;
        dec_last      = 1'b0;
        dec_load_done = 1'b0;
        dec_scan      = 1'b0;
        dec_status    = pte_pkg::ST_OK;
        dec_op        = pte_pkg::OP_READ;
        dec_target    = cmd.position;
        dec_del_n     = cmd.count;
        eff_kind      = run_kind_reg;
        eff_rej       = run_rej_reg;
        eff_pos       = run_pos_reg;
        eff_total     = run_total_reg;
        eff_recv      = run_recv_reg;
        if (!run_open_reg)
        begin
            case (cmd.kind)
                pte_pkg::KIND_LOAD:
                begin
                    if (cmd.count == 14'd0)
                    begin
                        dec_emit  = 1'b1;
                        dec_clear = 1'b1;
                    end
                    else
                    begin
                        dec_open = 1'b1;
                        eff_rej  = (18'(cmd.count) > OD_L) ? pte_pkg::ST_FULL : pte_pkg::ST_OK;
                    end
                end
                pte_pkg::KIND_INSERT:
                begin
                    if (cmd.position > tl_reg)
                    begin
                        eff_rej = pte_pkg::ST_RANGE;
                        if (cmd.count == 14'd0)
                        begin
                            dec_emit   = 1'b1;
                            dec_status = pte_pkg::ST_RANGE;
                        end
                        else
                        begin
                            dec_open = 1'b1;
                        end
                    end
                    else if (cmd.count == 14'd0)
                    begin
                        dec_emit = 1'b1;
                    end
                    else
                    begin
                        dec_open = 1'b1;
                        if ((18'(added_reg) + 18'(cmd.count) > AD_L) ||
                            (15'(tl_reg) + 15'(cmd.count) > 15'(pte_pkg::LENGTH_LIMIT)))
                        begin
                            eff_rej = pte_pkg::ST_FULL;
                        end
                        else
                        begin
                            eff_rej = pte_pkg::ST_OK;
                        end
                    end
                end
                pte_pkg::KIND_DELETE:
                begin
                    dec_del_n = (cmd.count > avail) ? avail : cmd.count;
                    if (cmd.position > tl_reg)
                    begin
                        dec_emit   = 1'b1;
                        dec_status = pte_pkg::ST_RANGE;
                    end
                    else if (dec_del_n == 14'd0)
                    begin
                        dec_emit = 1'b1;
                    end
                    else
                    begin
                        dec_scan = 1'b1;
                        dec_op   = pte_pkg::OP_DEL;
                    end
                end
                default:
                begin
                    if (cmd.position >= tl_reg)
                    begin
                        dec_emit   = 1'b1;
                        dec_status = pte_pkg::ST_RANGE;
                    end
                    else
                    begin
                        dec_scan = 1'b1;
                        dec_op   = pte_pkg::OP_READ;
                    end
                end
            endcase
            if (dec_open)
            begin
                eff_kind  = cmd.kind;
                eff_pos   = cmd.position;
                eff_total = cmd.count;
                eff_recv  = 14'd0;
            end
        end
        dec_step = run_open_reg || dec_open;
        if (dec_step)
        begin
            dec_last = (15'(eff_recv) + 15'd1) >= 15'(eff_total);
            if (dec_last)
            begin
                if (eff_rej != pte_pkg::ST_OK)
                begin
                    dec_emit   = 1'b1;
                    dec_status = eff_rej;
                end
                else if (eff_kind == pte_pkg::KIND_LOAD)
                begin
                    dec_emit      = 1'b1;
                    dec_load_done = 1'b1;
                end
                else
                begin
                    dec_scan   = 1'b1;
                    dec_op     = pte_pkg::OP_INSERT;
                    dec_target = eff_pos;
                end
            end
        end
    end

    // ---------------------------------------------------------------- shared terms
    pte_pkg::piece_t  new_piece;
    logic [17:0]      fetch_addr;
    logic [14:0]      scan_end;
    logic             ext_ok;

    assign new_piece  = '{src: 1'b1, off: pte_pkg::OFF_W'(added_reg), len: run_total_reg};
    assign fetch_addr = 18'(hit_reg.off) + 18'(within_reg);
    assign scan_end   = 15'(acc_reg) + 15'(pr_data.len);
    assign ext_ok     = (loc_idx_reg != '0) && (within_reg == 14'd0) && prev_reg.src &&
                        ((18'(prev_reg.off) + 18'(prev_reg.len)) == 18'(added_reg));

    // delete planning terms
    logic [MW-1:0] d_s, d_d, d_m, d_left;
    logic          d_h, d_t;

    assign d_h    = (i0_reg < count_reg) && (w0_reg != 14'd0);
    assign d_t    = (loc_idx_reg < count_reg) && (within_reg != 14'd0);
    assign d_s    = MW'(loc_idx_reg) + MW'(d_t);
    assign d_d    = MW'(i0_reg) + MW'(d_h) + MW'(d_t);
    assign d_left = MW'(count_reg) - d_s;
    assign d_m    = d_d + d_left;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pte_pkg::S_IDLE:
            begin
                if (accept && dec_scan)
                begin
                    state_next = pte_pkg::S_SCAN_RD;
                end
            end
            pte_pkg::S_SCAN_RD:
            begin
                state_next = (scan_i_reg >= count_reg) ? pte_pkg::S_LOCATED
                                                       : pte_pkg::S_SCAN_CHK;
            end
            pte_pkg::S_SCAN_CHK:
            begin
                state_next = (15'(target_reg) < scan_end) ? pte_pkg::S_LOCATED
                                                          : pte_pkg::S_SCAN_RD;
            end
            pte_pkg::S_LOCATED:
            begin
                case (op_reg)
                    pte_pkg::OP_READ:
                        state_next = found_reg ? pte_pkg::S_RD_DATA : pte_pkg::S_IDLE;
                    pte_pkg::OP_INSERT:
                        state_next = pte_pkg::S_INS_DECIDE;
                    default:
                        state_next = phase_reg ? pte_pkg::S_DEL_DECIDE : pte_pkg::S_SCAN_RD;
                endcase
            end
            pte_pkg::S_RD_DATA:
            begin
                state_next = pte_pkg::S_IDLE;
            end
            pte_pkg::S_INS_DECIDE:
            begin
                if (ext_ok || !found_reg ||
                    (MW'(count_reg) + ((within_reg != 14'd0) ? MW'(2) : MW'(1)) > MAXP))
                begin
                    state_next = pte_pkg::S_IDLE;
                end
                else
                begin
                    state_next = pte_pkg::S_SHIFT_RD;
                end
            end
            pte_pkg::S_SHIFT_RD:
            begin
                if (sh_left_reg != '0)
                begin
                    state_next = pte_pkg::S_SHIFT_WR;
                end
                else
                begin
                    state_next = (op_reg == pte_pkg::OP_INSERT) ? pte_pkg::S_INS_W0
                                                                : pte_pkg::S_DEL_WH;
                end
            end
            pte_pkg::S_SHIFT_WR:
            begin
                state_next = pte_pkg::S_SHIFT_RD;
            end
            pte_pkg::S_INS_W0:
            begin
                state_next = split_reg ? pte_pkg::S_INS_W1 : pte_pkg::S_IDLE;
            end
            pte_pkg::S_INS_W1:
            begin
                state_next = pte_pkg::S_INS_W2;
            end
            pte_pkg::S_INS_W2:
            begin
                state_next = pte_pkg::S_IDLE;
            end
            pte_pkg::S_DEL_DECIDE:
            begin
                state_next = (d_m > MAXP) ? pte_pkg::S_IDLE : pte_pkg::S_SHIFT_RD;
            end
            pte_pkg::S_DEL_WH:
            begin
                state_next = pte_pkg::S_DEL_WT;
            end
            pte_pkg::S_DEL_WT:
            begin
                state_next = pte_pkg::S_IDLE;
            end
            default:
            begin
                state_next = pte_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- memory controls
    always_comb
    begin
        pw_we   = 1'b0;
        pw_addr = '0;
        pw_data = new_piece;
        pr_addr = scan_i_reg[IDX_W-1:0];
        ow_we   = 1'b0;
        ow_addr = OA_W'(eff_recv);
        aw_we   = 1'b0;
        aw_addr = AA_W'(18'(added_reg) + 18'(eff_recv));
        or_addr = fetch_addr[OA_W-1:0];
        ar_addr = fetch_addr[AA_W-1:0];
        case (state_reg)
            pte_pkg::S_IDLE:
            begin
                if (accept && dec_step && (eff_rej == pte_pkg::ST_OK))
                begin
                    ow_we = (eff_kind == pte_pkg::KIND_LOAD);
                    aw_we = (eff_kind != pte_pkg::KIND_LOAD);
                end
                if (accept && dec_load_done)
                begin
                    pw_we   = 1'b1;
                    pw_addr = '0;
                    pw_data = '{src: 1'b0, off: '0, len: eff_total};
                end
            end
            pte_pkg::S_INS_DECIDE:
            begin
                if (ext_ok)
                begin
                    pw_we   = 1'b1;
                    pw_addr = IDX_W'(loc_idx_reg - PC_W'(1));
                    pw_data = '{src: prev_reg.src, off: prev_reg.off,
                                len: prev_reg.len + run_total_reg};
                end
                else if (!found_reg &&
                         (MW'(count_reg) + MW'(1) <= MAXP))
                begin
                    pw_we   = 1'b1;
                    pw_addr = count_reg[IDX_W-1:0];
                end
            end
            pte_pkg::S_SHIFT_RD:
            begin
                pr_addr = sh_src_reg[IDX_W-1:0];
            end
            pte_pkg::S_SHIFT_WR:
            begin
                pw_we   = 1'b1;
                pw_addr = sh_dst_reg[IDX_W-1:0];
                pw_data = pr_data;
            end
            pte_pkg::S_INS_W0:
            begin
                pw_we   = 1'b1;
                pw_addr = loc_idx_reg[IDX_W-1:0];
                if (split_reg)
                begin
                    pw_data = '{src: hit_reg.src, off: hit_reg.off, len: within_reg};
                end
            end
            pte_pkg::S_INS_W1:
            begin
                pw_we   = 1'b1;
                pw_addr = IDX_W'(loc_idx_reg + PC_W'(1));
            end
            pte_pkg::S_INS_W2:
            begin
                pw_we   = 1'b1;
                pw_addr = IDX_W'(loc_idx_reg + PC_W'(2));
                pw_data = '{src: hit_reg.src,
                            off: hit_reg.off + pte_pkg::OFF_W'(within_reg),
                            len: hit_reg.len - within_reg};
            end
            pte_pkg::S_DEL_WH:
            begin
                pw_we   = dh_reg;
                pw_addr = i0_reg[IDX_W-1:0];
                pw_data = '{src: head_reg.src, off: head_reg.off, len: w0_reg};
            end
            pte_pkg::S_DEL_WT:
            begin
                pw_we   = dt_reg;
                pw_addr = IDX_W'(i0_reg + PC_W'(dh_reg));
                pw_data = '{src: hit_reg.src,
                            off: hit_reg.off + pte_pkg::OFF_W'(within_reg),
                            len: hit_reg.len - within_reg};
            end
            default:
            begin
                pw_we = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        count_next     = count_reg;
        tl_next        = tl_reg;
        added_next     = added_reg;
        run_open_next  = run_open_reg;
        run_kind_next  = run_kind_reg;
        run_pos_next   = run_pos_reg;
        run_total_next = run_total_reg;
        run_recv_next  = run_recv_reg;
        run_rej_next   = run_rej_reg;
        op_next        = op_reg;
        phase_next     = phase_reg;
        target_next    = target_reg;
        del_n_next     = del_n_reg;
        scan_i_next    = scan_i_reg;
        acc_next       = acc_reg;
        found_next     = found_reg;
        loc_idx_next   = loc_idx_reg;
        within_next    = within_reg;
        hit_next       = hit_reg;
        prev_next      = prev_reg;
        i0_next        = i0_reg;
        w0_next        = w0_reg;
        head_next      = head_reg;
        dh_next        = dh_reg;
        dt_next        = dt_reg;
        dm_next        = dm_reg;
        sh_src_next    = sh_src_reg;
        sh_dst_next    = sh_dst_reg;
        sh_left_next   = sh_left_reg;
        sh_desc_next   = sh_desc_reg;
        split_next     = split_reg;
        fetch_ok_next  = fetch_ok_reg;
        fetch_src_next = fetch_src_reg;
        done_next      = 1'b0;
        res_next       = res_reg;

        case (state_reg)
            pte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (dec_clear)
                    begin
                        count_next = '0;
                        tl_next    = 14'd0;
                    end
                    if (dec_open)
                    begin
                        run_open_next  = 1'b1;
                        run_kind_next  = eff_kind;
                        run_pos_next   = eff_pos;
                        run_total_next = eff_total;
                        run_rej_next   = eff_rej;
                    end
                    if (dec_step)
                    begin
                        if (dec_last)
                        begin
                            run_open_next = 1'b0;
                            run_recv_next = 14'd0;
                            run_rej_next  = pte_pkg::ST_OK;
                        end
                        else
                        begin
                            run_recv_next = eff_recv + 14'd1;
                        end
                    end
                    if (dec_load_done)
                    begin
                        count_next = PC_W'(1);
                        tl_next    = eff_total;
                    end
                    if (dec_scan)
                    begin
                        op_next     = dec_op;
                        phase_next  = 1'b0;
                        target_next = dec_target;
                        del_n_next  = dec_del_n;
                        scan_i_next = '0;
                        acc_next    = 14'd0;
                    end
                    if (dec_emit)
                    begin
                        done_next           = 1'b1;
                        res_next.status     = dec_status;
                        res_next.read_valid = 1'b0;
                        res_next.read_byte  = 8'd0;
                    end
                end
            end
            pte_pkg::S_SCAN_RD:
            begin
                if (scan_i_reg >= count_reg)
                begin
                    found_next   = 1'b0;
                    loc_idx_next = count_reg;
                    within_next  = 14'd0;
                end
            end
            pte_pkg::S_SCAN_CHK:
            begin
                if (15'(target_reg) < scan_end)
                begin
                    found_next   = 1'b1;
                    loc_idx_next = scan_i_reg;
                    within_next  = target_reg - acc_reg;
                    hit_next     = pr_data;
                end
                else
                begin
                    prev_next   = pr_data;
                    acc_next    = scan_end[13:0];
                    scan_i_next = scan_i_reg + PC_W'(1);
                end
            end
            pte_pkg::S_LOCATED:
            begin
                case (op_reg)
                    pte_pkg::OP_READ:
                    begin
                        fetch_src_next = hit_reg.src;
                        fetch_ok_next  = hit_reg.src ? (fetch_addr < AD_L)
                                                     : (fetch_addr < OD_L);
                        if (!found_reg)
                        begin
                            done_next           = 1'b1;
                            res_next.status     = pte_pkg::ST_RANGE;
                            res_next.read_valid = 1'b0;
                            res_next.read_byte  = 8'd0;
                        end
                    end
                    pte_pkg::OP_INSERT:
                    begin
                        split_next = found_reg && (within_reg != 14'd0);
                    end
                    default:
                    begin
                        if (!phase_reg)
                        begin
                            i0_next     = loc_idx_reg;
                            w0_next     = within_reg;
                            head_next   = hit_reg;
                            phase_next  = 1'b1;
                            target_next = target_reg + del_n_reg;
                            scan_i_next = '0;
                            acc_next    = 14'd0;
                        end
                    end
                endcase
            end
            pte_pkg::S_RD_DATA:
            begin
                done_next           = 1'b1;
                res_next.status     = pte_pkg::ST_OK;
                res_next.read_valid = 1'b1;
                res_next.read_byte  = fetch_ok_reg ? (fetch_src_reg ? a_q : o_q) : 8'd0;
            end
            pte_pkg::S_INS_DECIDE:
            begin
                res_next.read_valid = 1'b0;
                res_next.read_byte  = 8'd0;
                res_next.status     = pte_pkg::ST_OK;
                if (ext_ok)
                begin
                    done_next  = 1'b1;
                    added_next = AL_W'(18'(added_reg) + 18'(run_total_reg));
                    tl_next    = tl_reg + run_total_reg;
                end
                else if (MW'(count_reg) + (split_reg ? MW'(2) : MW'(1)) > MAXP)
                begin
                    done_next       = 1'b1;
                    res_next.status = pte_pkg::ST_FULL;
                end
                else if (!found_reg)
                begin
                    done_next  = 1'b1;
                    count_next = count_reg + PC_W'(1);
                    added_next = AL_W'(18'(added_reg) + 18'(run_total_reg));
                    tl_next    = tl_reg + run_total_reg;
                end
                else
                begin
                    // move the pieces above the insert point up by one or two
                    sh_desc_next = 1'b1;
                    sh_src_next  = count_reg - PC_W'(1);
                    if (split_reg)
                    begin
                        sh_left_next = count_reg - loc_idx_reg - PC_W'(1);
                        sh_dst_next  = count_reg + PC_W'(1);
                    end
                    else
                    begin
                        sh_left_next = count_reg - loc_idx_reg;
                        sh_dst_next  = count_reg;
                    end
                end
            end
            pte_pkg::S_SHIFT_WR:
            begin
                sh_left_next = sh_left_reg - PC_W'(1);
                if (sh_desc_reg)
                begin
                    sh_src_next = sh_src_reg - PC_W'(1);
                    sh_dst_next = sh_dst_reg - PC_W'(1);
                end
                else
                begin
                    sh_src_next = sh_src_reg + PC_W'(1);
                    sh_dst_next = sh_dst_reg + PC_W'(1);
                end
            end
            pte_pkg::S_INS_W0:
            begin
                if (!split_reg)
                begin
                    done_next  = 1'b1;
                    count_next = count_reg + PC_W'(1);
                    added_next = AL_W'(18'(added_reg) + 18'(run_total_reg));
                    tl_next    = tl_reg + run_total_reg;
                end
            end
            pte_pkg::S_INS_W2:
            begin
                done_next  = 1'b1;
                count_next = count_reg + PC_W'(2);
                added_next = AL_W'(18'(added_reg) + 18'(run_total_reg));
                tl_next    = tl_reg + run_total_reg;
            end
            pte_pkg::S_DEL_DECIDE:
            begin
                res_next.read_valid = 1'b0;
                res_next.read_byte  = 8'd0;
                res_next.status     = pte_pkg::ST_OK;
                dh_next = d_h;
                dt_next = d_t;
                dm_next = PC_W'(d_m);
                if (d_m > MAXP)
                begin
                    done_next       = 1'b1;
                    res_next.status = pte_pkg::ST_FULL;
                end
                else
                begin
                    sh_left_next = PC_W'(d_left);
                    // split inside one piece moves the tail up, else down
                    if (d_d > d_s)
                    begin
                        sh_desc_next = 1'b1;
                        sh_src_next  = count_reg - PC_W'(1);
                        sh_dst_next  = PC_W'(MW'(count_reg) - MW'(1) + d_d - d_s);
                    end
                    else
                    begin
                        sh_desc_next = 1'b0;
                        sh_src_next  = PC_W'(d_s);
                        sh_dst_next  = PC_W'(d_d);
                    end
                end
            end
            pte_pkg::S_DEL_WT:
            begin
                done_next  = 1'b1;
                count_next = dm_reg;
                tl_next    = tl_reg - del_n_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        res_next.total_length = done_next ? tl_next : res_reg.total_length;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pte_pkg::S_IDLE;
            count_reg    <= '0;
            tl_reg       <= 14'd0;
            added_reg    <= '0;
            run_open_reg <= 1'b0;
            run_recv_reg <= 14'd0;
            run_rej_reg  <= pte_pkg::ST_OK;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            tl_reg       <= tl_next;
            added_reg    <= added_next;
            run_open_reg <= run_open_next;
            run_recv_reg <= run_recv_next;
            run_rej_reg  <= run_rej_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_kind_reg  <= run_kind_next;
        run_pos_reg   <= run_pos_next;
        run_total_reg <= run_total_next;
        op_reg        <= op_next;
        phase_reg     <= phase_next;
        target_reg    <= target_next;
        del_n_reg     <= del_n_next;
        scan_i_reg    <= scan_i_next;
        acc_reg       <= acc_next;
        found_reg     <= found_next;
        loc_idx_reg   <= loc_idx_next;
        within_reg    <= within_next;
        hit_reg       <= hit_next;
        prev_reg      <= prev_next;
        i0_reg        <= i0_next;
        w0_reg        <= w0_next;
        head_reg      <= head_next;
        dh_reg        <= dh_next;
        dt_reg        <= dt_next;
        dm_reg        <= dm_next;
        sh_src_reg    <= sh_src_next;
        sh_dst_reg    <= sh_dst_next;
        sh_left_reg   <= sh_left_next;
        sh_desc_reg   <= sh_desc_next;
        split_reg     <= split_next;
        fetch_ok_reg  <= fetch_ok_next;
        fetch_src_reg <= fetch_src_next;
        res_reg       <= res_next;
    end

    assign busy   = (state_reg != pte_pkg::S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // ---------------------------------------------------------------- checks
    `PTE_ASSERT_NOW(a_done_idle, done_reg, state_reg == pte_pkg::S_IDLE, "result while busy")
    `PTE_ASSERT_NOW(a_run_idle, run_open_reg, state_reg == pte_pkg::S_IDLE, "run open in walk")
    `PTE_ASSERT_NOW(a_count_max, 1'b1, MW'(count_reg) <= MAXP, "piece count past table")
    `PTE_ASSERT_NOW(a_empty_len, count_reg == '0, tl_reg == 14'd0, "text with no pieces")
    `PTE_ASSERT_NOW(a_read_ok, done_reg && res_reg.read_valid,
                    res_reg.status == pte_pkg::ST_OK, "valid read with error")

endmodule

`default_nettype wire

// File: sim/piece_table_text_editor_unit_tb.sv
// ----------------------------------------------------------------------------
// piece_table_text_editor_unit_tb
// Self-checking bench: drives load, insert, delete and read words, predicts
// every result from a behavioural piece-table model and compares field-wise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piece_table_text_editor_unit_tb;

    localparam int ORIG_D   = 4096;
    localparam int ADD_D    = 4096;
    localparam int MAXP     = 64;
    localparam int IDLE_CAP = 20000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    pte_pkg::cmd_t cmd;
    logic          done;
    pte_pkg::res_t result;

    piece_table_text_editor_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---- shadow of the text store ----
    typedef struct {
        bit          from_add;
        int unsigned off;
        int unsigned len;
    } span_t;

    byte unsigned orig_mem [ORIG_D];
    byte unsigned add_mem  [ADD_D];
    span_t        spans    [$];
    int unsigned  text_len;
    int unsigned  add_fill;
    bit           run_live;
    logic [1:0]   run_kind;
    int unsigned  run_pos;
    int unsigned  run_total;
    int unsigned  run_got;
    logic [1:0]   run_err;

    pte_pkg::res_t expected_words [$];
    int   mismatches;
    int   idle_cycles;
    bit   timed_out;
    bit   no_gaps;

    // find piece index and offset within it for a text position
    function automatic void find_span(input int unsigned p, output int unsigned idx,
                                      output int unsigned w);
        int unsigned acc;
        acc = 0;
        for (int i = 0; i < spans.size(); i++)
        begin
            if (p < acc + spans[i].len)
            begin
                idx = i;
                w   = p - acc;
                return;
            end
            acc += spans[i].len;
        end
        idx = spans.size();
        w   = 0;
    endfunction

    function automatic logic [1:0] splice_insert(input int unsigned p, input int unsigned n);
        int unsigned idx, w, need;
        span_t ns, old, tl;
        find_span(p, idx, w);
        if (idx > 0 && w == 0 && spans[idx-1].from_add
            && spans[idx-1].off + spans[idx-1].len == add_fill)
        begin
            spans[idx-1].len += n;
            add_fill += n;
            text_len += n;
            return pte_pkg::ST_OK;
        end
        need = (idx >= spans.size() || w == 0) ? 1 : 2;
        if (spans.size() + need > MAXP)
            return pte_pkg::ST_FULL;
        ns.from_add = 1'b1;
        ns.off = add_fill;
        ns.len = n;
        if (idx >= spans.size())
            spans.push_back(ns);
        else if (w == 0)
            spans.insert(idx, ns);
        else
        begin
            old = spans[idx];
            tl = old;
            tl.off = old.off + w;
            tl.len = old.len - w;
            spans[idx].len = w;
            spans.insert(idx + 1, tl);
            spans.insert(idx + 1, ns);
        end
        add_fill += n;
        text_len += n;
        return pte_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] cut_range(input int unsigned p, input int unsigned n);
        int unsigned i0, w0, i1, w1;
        span_t nl [$];
        span_t s;
        if (p > text_len)
            return pte_pkg::ST_RANGE;
        if (n > text_len - p)
            n = text_len - p;
        if (n == 0)
            return pte_pkg::ST_OK;
        find_span(p, i0, w0);
        find_span(p + n, i1, w1);
        for (int i = 0; i < i0; i++)
            nl.push_back(spans[i]);
        if (i0 < spans.size() && w0 > 0)
        begin
            s = spans[i0];
            s.len = w0;
            nl.push_back(s);
        end
        if (i1 < spans.size() && w1 > 0)
        begin
            s = spans[i1];
            s.off += w1;
            s.len -= w1;
            nl.push_back(s);
        end
        for (int i = i1 + (w1 > 0 ? 1 : 0); i < spans.size(); i++)
            nl.push_back(spans[i]);
        if (nl.size() > MAXP)
            return pte_pkg::ST_FULL;
        spans = nl;
        text_len -= n;
        return pte_pkg::ST_OK;
    endfunction

    function automatic void queue_result(input logic [1:0] st, input bit v,
                                         input byte unsigned b);
        pte_pkg::res_t r;
        r.status = st;
        r.read_valid = v;
        r.read_byte = b;
        r.total_length = text_len[13:0];
        expected_words.push_back(r);
    endfunction

    // advance the shadow by one accepted word
    function automatic void predict_word(input pte_pkg::cmd_t c);
        int unsigned p, n, idx, w, a;
        logic [1:0] st;
        p = c.position;
        n = c.count;
        if (!run_live)
        begin
            case (c.kind)
                pte_pkg::KIND_LOAD:
                begin
                    if (n == 0)
                    begin
                        spans.delete();
                        text_len = 0;
                        queue_result(pte_pkg::ST_OK, 0, 0);
                        return;
                    end
                    run_err = (n > ORIG_D) ? pte_pkg::ST_FULL : pte_pkg::ST_OK;
                end
                pte_pkg::KIND_INSERT:
                begin
                    if (p > text_len)
                        run_err = pte_pkg::ST_RANGE;
                    else if (n == 0)
                        run_err = pte_pkg::ST_OK;
                    else if (add_fill + n > ADD_D || text_len + n > 16383)
                        run_err = pte_pkg::ST_FULL;
                    else
                        run_err = pte_pkg::ST_OK;
                    if (n == 0)
                    begin
                        queue_result(run_err, 0, 0);
                        run_err = pte_pkg::ST_OK;
                        return;
                    end
                end
                pte_pkg::KIND_DELETE:
                begin
                    st = cut_range(p, n);
                    queue_result(st, 0, 0);
                    return;
                end
                default:
                begin
                    if (p >= text_len)
                        queue_result(pte_pkg::ST_RANGE, 0, 0);
                    else
                    begin
                        find_span(p, idx, w);
                        a = spans[idx].off + w;
                        queue_result(pte_pkg::ST_OK, 1,
                                     spans[idx].from_add ? add_mem[a] : orig_mem[a]);
                    end
                    return;
                end
            endcase
            run_live = 1;
            run_kind = c.kind;
            run_pos = p;
            run_total = n;
            run_got = 0;
        end
        if (run_err == pte_pkg::ST_OK)
        begin
            if (run_kind == pte_pkg::KIND_LOAD)
            begin
                if (run_got < ORIG_D)
                    orig_mem[run_got] = c.data_byte;
            end
            else
            begin
                a = add_fill + run_got;
                if (a < ADD_D)
                    add_mem[a] = c.data_byte;
            end
        end
        run_got++;
        if (run_got < run_total)
            return;
        run_live = 0;
        st = run_err;
        run_err = pte_pkg::ST_OK;
        if (st == pte_pkg::ST_OK)
        begin
            if (run_kind == pte_pkg::KIND_LOAD)
            begin
                span_t s;
                s.from_add = 0;
                s.off = 0;
                s.len = run_total;
                spans.delete();
                spans.push_back(s);
                text_len = run_total;
            end
            else
                st = splice_insert(run_pos, run_total);
        end
        queue_result(st, 0, 0);
    endfunction

    // ---- word sender: start stays high between back-to-back words ----
    task automatic send_word(input logic [1:0] k, input int unsigned p,
                             input int unsigned n, input byte unsigned d);
        pte_pkg::cmd_t c;
        if (!no_gaps)
            while ($urandom_range(99) < 35)
            begin
                start <= 1'b0;
                cmd <= pte_pkg::cmd_t'(38'({$urandom, $urandom}));
                @(posedge clk);
            end
        c.kind = k;
        c.position = p[13:0];
        c.count = n[13:0];
        c.data_byte = d;
        cmd <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(c);
    endtask

    task automatic send_run(input logic [1:0] k, input int unsigned p, input int unsigned n);
        send_word(k, p, n, 8'($urandom));
        for (int i = 1; i < n; i++)
            send_word(2'($urandom), $urandom, $urandom, 8'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_words.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // ---- result checker: done is a one-cycle strobe ----
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %p", result);
            end
            else
            begin
                pte_pkg::res_t e;
                e = expected_words.pop_front();
                if (result.status !== e.status || result.read_valid !== e.read_valid
                    || result.read_byte !== e.read_byte
                    || result.total_length !== e.total_length)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p actual %p", e, result);
                end
            end
        end
    end

    // ---- watchdog: cycles with nothing accepted and no result ----
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_CAP && !timed_out)
        begin
            timed_out = 1;
            $display("FAIL piece_table_text_editor_unit");
            $finish;
        end
    end

    // ---- tests ----
    task automatic test_edges();
        send_word(pte_pkg::KIND_READ, 0, 0, 0);          // read on empty text
        send_word(pte_pkg::KIND_DELETE, 0, 5, 0);        // delete on empty text
        send_word(pte_pkg::KIND_DELETE, 1, 0, 0);        // delete beyond end
        send_word(pte_pkg::KIND_INSERT, 3, 0, 0);        // insert out of range, no bytes
        send_word(pte_pkg::KIND_INSERT, 0, 0, 0);        // empty insert
        send_word(pte_pkg::KIND_LOAD, 0, 0, 0);          // load of nothing
        send_run(pte_pkg::KIND_LOAD, 0, 6);
        send_word(pte_pkg::KIND_READ, 5, 0, 0);
        send_word(pte_pkg::KIND_READ, 6, 0, 0);
        send_word(pte_pkg::KIND_READ, 16383, 16383, 255);
        send_run(pte_pkg::KIND_INSERT, 9, 2);            // out-of-range run, bytes dropped
        send_run(pte_pkg::KIND_INSERT, 3, 2);            // split
        send_run(pte_pkg::KIND_INSERT, 5, 2);            // extends the add piece
        send_run(pte_pkg::KIND_INSERT, 0, 1);            // head
        send_run(pte_pkg::KIND_INSERT, 11, 1);           // tail
        send_word(pte_pkg::KIND_DELETE, 2, 4, 0);
        send_word(pte_pkg::KIND_DELETE, 3, 16383, 0);    // clamped
        send_word(pte_pkg::KIND_READ, 1, 0, 0);
    endtask

    task automatic test_fill_table();
        // many single splits until the piece table rejects
        send_run(pte_pkg::KIND_LOAD, 0, 200);
        for (int i = 0; i < 40; i++)
            send_run(pte_pkg::KIND_INSERT, 1 + 3 * i, 1);
        for (int i = 0; i < 30; i++)
            send_word(pte_pkg::KIND_READ, $urandom_range(text_len), 0, 0);
        send_word(pte_pkg::KIND_DELETE, 1, 1, 0);
        send_word(pte_pkg::KIND_DELETE, 2, 20, 0);
    endtask

    task automatic test_random(input int items);
        int unsigned r;
        for (int i = 0; i < items; i++)
        begin
            no_gaps = (i >= items / 2 && i < items / 2 + items / 4);
            r = $urandom_range(99);
            if (add_fill > ADD_D - 200 || text_len == 0 && r < 50)
            begin
                send_run(pte_pkg::KIND_LOAD, 0, $urandom_range(1, 40));
                if (add_fill > ADD_D - 200)
                    send_run(pte_pkg::KIND_INSERT, 0, $urandom_range(200, 300));
            end
            else if (r < 30)
                send_run(pte_pkg::KIND_INSERT, $urandom_range(text_len), $urandom_range(1, 6));
            else if (r < 38)
                send_word(pte_pkg::KIND_INSERT, $urandom_range(text_len + 3),
                          $urandom_range(0, 3), 8'($urandom));
            else if (r < 55)
                send_word(pte_pkg::KIND_DELETE, $urandom_range(text_len + 2),
                          $urandom_range(0, 12), 8'($urandom));
            else if (r < 92)
                send_word(pte_pkg::KIND_READ, $urandom_range(text_len + 1), $urandom,
                          8'($urandom));
            else if (r < 96)
                send_run(pte_pkg::KIND_LOAD, 0, $urandom_range(1, 60));
            else
                send_word(2'($urandom), $urandom, $urandom, 8'($urandom));
        end
        no_gaps = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        text_len = 0;
        add_fill = 0;
        run_live = 0;
        run_err = pte_pkg::ST_OK;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 0;
        no_gaps = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges();
        test_fill_table();
        test_random(290);

        wait_drained();
        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASS piece_table_text_editor_unit");
        else
            $display("FAIL piece_table_text_editor_unit");
        $finish;
    end

endmodule
